// ===== src/rrgn_pkg.sv =====
// Package: shared constants and codes of the running RMS gain normalizer.
`timescale 1ns / 1ps
`default_nettype none
package rrgn_pkg;
  localparam int unsigned MaxFrame   = 1024;
  localparam int unsigned FrameAw    = $clog2(MaxFrame);
  localparam int unsigned RamAw      = FrameAw + 1;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned CountW     = 11;
  localparam int unsigned SumW       = 40;
  localparam int unsigned DvdW       = 56;
  localparam int unsigned DvsW       = 28;
  localparam int unsigned RootW      = 28;
  localparam int unsigned LevelW     = 28;
  localparam int unsigned GainW      = 16;

  localparam logic [LevelW-1:0] RmsFloor  = 28'd8;
  localparam logic [11:0]       AlphaQ16  = 12'd3277;
  localparam logic [15:0]       BetaQ16   = 16'd62259;
  localparam logic [GainW-1:0]  GainUnity = 16'd2048;
  localparam logic [GainW-1:0]  GainMin   = 16'd205;
  localparam logic [GainW-1:0]  GainMax   = 16'd40960;
  localparam logic [10:0]       FrameLengthReset = 11'd800;
  localparam logic [14:0]       TargetLevelReset = 15'd1835;

  typedef enum logic [1:0] {
    CFG_FRAME_LENGTH = 2'd0,
    CFG_TARGET_LEVEL = 2'd1
  } cfg_index_e;
endpackage
`default_nettype wire

// ===== src/rrgn_in_if.sv =====
// Interface: input sample channel.
`timescale 1ns / 1ps
`default_nettype none
interface rrgn_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               has_sample;
  modport source (output valid, output sample_in, output has_sample, input ready);
  modport sink (input valid, input sample_in, input has_sample, output ready);
endinterface
`default_nettype wire

// ===== src/rrgn_out_if.sv =====
// Interface: scaled result channel.
`timescale 1ns / 1ps
`default_nettype none
interface rrgn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scaled_sample;
  logic [15:0]        frame_gain;
  logic               frame_end;
  modport source (output valid, output scaled_sample, output frame_gain, output frame_end,
                  input ready);
  modport sink (input valid, input scaled_sample, input frame_gain, input frame_end,
                output ready);
endinterface
`default_nettype wire

// ===== src/rrgn_cfg_if.sv =====
// Interface: configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface rrgn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/rrgn_frame_ram.sv =====
// Two-bank frame store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rrgn_frame_ram
  import rrgn_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [RamAw-1:0]      waddr_i,
  input  wire logic [SampleBits-1:0] wdata_i,
  input  wire logic                  re_i,
  input  wire logic [RamAw-1:0]      raddr_i,
  output logic      [SampleBits-1:0] rdata_o
);
  logic [SampleBits-1:0] mem_q [2*MaxFrame];

  // write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== src/rrgn_divider.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rrgn_divider
  import rrgn_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DvdW-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   rem_q;
  logic [DvsW:0]   rem_sh;
  logic            fits;

  assign rem_sh     = {rem_q[DvsW-1:0], dvd_q[DvdW-1]};
  assign fits       = rem_sh >= {1'b0, dvs_q};
  assign quotient_o = dvd_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == CntW'(DvdW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      dvd_q <= {dvd_q[DvdW-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ===== src/rrgn_isqrt.sv =====
// Serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rrgn_isqrt
  import rrgn_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DvdW-1:0]  radicand_i,
  output logic                  done_o,
  output logic      [RootW-1:0] root_o
);
  localparam int unsigned CntW = $clog2(RootW);
  localparam int unsigned RemW = RootW + 2;

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DvdW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;
  logic             fits;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[DvdW-1:DvdW-2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;
  assign root_o = root_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == CntW'(RootW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath: bring down two bits, try the next root bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[DvdW-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RootW-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ===== src/running_rms_gain_normalizer.sv =====
// Top level: frame-wise RMS automatic gain control around a two-bank frame store.
// Each accepted transaction writes its sample, if it has one, into the active bank
// and reads one pending sample of the previous frame, if any, from the other bank;
// the result leaves through an output register after a multiply and saturate. A
// transaction that does not close a frame passes store access, multiply and output
// load, and may wait while the consumer holds the output register. A transaction
// that closes a frame then runs the serial units: a divide for the mean square, a
// square root, the seed or EMA update of the level and, when the level is above
// the floor, a divide for the gain. Configuration writes are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none
module running_rms_gain_normalizer
  import rrgn_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rrgn_in_if.sink    in_i,
  rrgn_out_if.source out_o,
  rrgn_cfg_if.sink   cfg_i
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL   = 12'b000000000010,
    S_OUT   = 12'b000000000100,
    S_DIVA  = 12'b000000001000,
    S_DIVAW = 12'b000000010000,
    S_SQRT  = 12'b000000100000,
    S_SQRTW = 12'b000001000000,
    S_EMA1  = 12'b000010000000,
    S_EMA2  = 12'b000100000000,
    S_DIVB  = 12'b001000000000,
    S_DIVBW = 12'b010000000000,
    S_CLOSE = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [10:0]       frame_length_q;
  logic [14:0]       target_level_q;
  logic [CountW-1:0] write_count_q, read_count_q, pending_q;
  logic              bank_q;
  logic [SumW-1:0]   sum_q;
  logic [LevelW-1:0] level_q;
  logic              seeded_q;
  logic [GainW-1:0]  gain_q;
  logic              rd_q, end_q, close_q;
  logic [LevelW-1:0] rms_q;
  logic [39:0]       mix_a_q;
  logic [43:0]       mix_b_q;
  logic signed [32:0] prod_q;

  logic              out_valid_q;
  logic signed [15:0] out_sample_q;
  logic [15:0]       out_gain_q;
  logic              out_end_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= FrameLengthReset;
      target_level_q <= TargetLevelReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FRAME_LENGTH: frame_length_q <= cfg_i.data[10:0];
        CFG_TARGET_LEVEL: target_level_q <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  // effective frame length
  logic [CountW-1:0] len;
  always_comb begin
    if (frame_length_q == '0) len = CountW'(1);
    else if (frame_length_q > CountW'(MaxFrame)) len = CountW'(MaxFrame);
    else len = frame_length_q;
  end

  // transaction decode
  logic in_acc, do_rd, do_wr;
  assign in_i.ready = state_q == S_IDLE;
  assign in_acc = in_i.valid && in_i.ready;
  assign do_rd  = in_acc && (pending_q != '0) && (read_count_q < CountW'(MaxFrame));
  assign do_wr  = in_acc && in_i.has_sample && (write_count_q < CountW'(MaxFrame));

  // square and saturating sum
  logic [31:0]       sq;
  logic [SumW:0]     sum_ext;
  logic [CountW-1:0] wc_next;
  assign sq      = 32'($signed(in_i.sample_in) * $signed(in_i.sample_in));
  assign sum_ext = {1'b0, sum_q} + {9'd0, sq};
  assign wc_next = write_count_q + 1'b1;

  // frame store
  logic [SampleBits-1:0] rdata;
  rrgn_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (do_wr),
    .waddr_i ({bank_q, write_count_q[FrameAw-1:0]}),
    .wdata_i (in_i.sample_in),
    .re_i    (do_rd),
    .raddr_i ({~bank_q, read_count_q[FrameAw-1:0]}),
    .rdata_o (rdata)
  );

  // serial units
  logic            div_start, div_done, sqrt_start, sqrt_done;
  logic [DvdW-1:0] div_dvd, div_q;
  logic [DvsW-1:0] div_dvs;
  logic [RootW-1:0] root;
  logic            level_ok;

  assign level_ok   = level_q > RmsFloor;
  assign div_start  = (state_q == S_DIVA) || ((state_q == S_DIVB) && level_ok);
  assign sqrt_start = state_q == S_SQRT;
  always_comb begin
    if (state_q == S_DIVA) begin
      div_dvd = {sum_q, 16'd0};
      div_dvs = {17'd0, write_count_q};
    end else begin
      div_dvd = {22'd0, ({19'd0, target_level_q} << 19)} + {29'd0, level_q[LevelW-1:1]};
      div_dvs = level_q;
    end
  end

  rrgn_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  rrgn_isqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // rounding and saturation of the scaled sample
  logic signed [32:0] rounded;
  logic signed [15:0] sat;
  assign rounded = (prod_q + 33'sd1024) >>> 11;
  always_comb begin
    if (rounded > 33'sd32767) sat = 16'sd32767;
    else if (rounded < -33'sd32768) sat = -16'sd32768;
    else sat = rounded[15:0];
  end

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  // clamped gain from the quotient
  logic [GainW-1:0] gain_clamped;
  always_comb begin
    if (div_q < DvdW'(GainMin)) gain_clamped = GainMin;
    else if (div_q > DvdW'(GainMax)) gain_clamped = GainMax;
    else gain_clamped = div_q[GainW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MUL;
      S_MUL:   state_d = S_OUT;
      S_OUT:   if (!rd_q || out_free) state_d = close_q ? S_DIVA : S_IDLE;
      S_DIVA:  state_d = S_DIVAW;
      S_DIVAW: if (div_done) state_d = S_SQRT;
      S_SQRT:  state_d = S_SQRTW;
      S_SQRTW: if (sqrt_done) state_d = S_EMA1;
      S_EMA1:  state_d = (seeded_q && (rms_q > RmsFloor)) ? S_EMA2 : S_DIVB;
      S_EMA2:  state_d = S_DIVB;
      S_DIVB:  state_d = level_ok ? S_DIVBW : S_CLOSE;
      S_DIVBW: if (div_done) state_d = S_CLOSE;
      S_CLOSE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      write_count_q <= '0;
      read_count_q  <= '0;
      pending_q     <= '0;
      bank_q        <= 1'b0;
      sum_q         <= '0;
      level_q       <= '0;
      seeded_q      <= 1'b0;
      gain_q        <= GainUnity;
      rd_q          <= 1'b0;
      close_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // load the result register or drop valid once the consumer takes it
      if (state_q == S_OUT && rd_q && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          rd_q    <= do_rd;
          close_q <= do_wr && (wc_next >= len);
          if (do_rd) begin
            pending_q    <= pending_q - 1'b1;
            read_count_q <= read_count_q + 1'b1;
          end
          if (do_wr) begin
            write_count_q <= wc_next;
            sum_q <= sum_ext[SumW] ? {SumW{1'b1}} : sum_ext[SumW-1:0];
          end
        end
        S_EMA1: if (!seeded_q) begin
          level_q  <= (rms_q > RmsFloor) ? rms_q : RmsFloor;
          seeded_q <= 1'b1;
        end
        S_EMA2: level_q <= {4'd0, 24'((45'(mix_a_q) + 45'(mix_b_q) + 45'd32768) >> 16)};
        S_DIVB: if (!level_ok) gain_q <= GainUnity;
        S_DIVBW: if (div_done) gain_q <= gain_clamped;
        S_CLOSE: begin
          bank_q        <= ~bank_q;
          pending_q     <= write_count_q;
          read_count_q  <= '0;
          write_count_q <= '0;
          sum_q         <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) end_q <= pending_q == CountW'(1);
    if (state_q == S_MUL) prod_q <= $signed(rdata) * $signed({1'b0, gain_q});
    if (state_q == S_OUT && rd_q && out_free) begin
      out_sample_q <= sat;
      out_gain_q   <= gain_q;
      out_end_q    <= end_q;
    end
    if (state_q == S_SQRTW && sqrt_done) rms_q <= root;
    if (state_q == S_EMA1) begin
      mix_a_q <= AlphaQ16 * rms_q;
      mix_b_q <= BetaQ16 * level_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.scaled_sample = out_sample_q;
  assign out_o.frame_gain    = out_gain_q;
  assign out_o.frame_end     = out_end_q;
endmodule
`default_nettype wire

// ===== dv/running_rms_gain_normalizer_test.sv =====
// Testbench: random and directed check of the running RMS gain normalizer.
`timescale 1ns / 1ps
`default_nettype none
module running_rms_gain_normalizer_test;
  import rrgn_pkg::*;

  typedef enum logic [1:0] { ROW_CFG, ROW_ITEM } row_kind_e;
  typedef enum logic [1:0] { CHK_PREDICT, CHK_NONE, CHK_TYPED } row_check_e;

  typedef struct packed {
    logic signed [15:0] scaled;
    logic [15:0]        gain;
    logic               fend;
  } scaled_out_t;

  typedef struct packed {
    row_kind_e          kind;
    cfg_index_e         idx;
    logic [15:0]        data;
    logic               has;
    logic signed [15:0] sample;
    row_check_e         chk;
    scaled_out_t        typed;
  } stim_row_t;

  localparam int unsigned SettleCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  rrgn_in_if  in_if ();
  rrgn_out_if out_if ();
  rrgn_cfg_if cfg_if ();

  running_rms_gain_normalizer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Mirror of the block's state
  logic [15:0]        store_mem [0:2*MaxFrame-1];
  int unsigned        wr_cnt, rd_cnt, pend_cnt, bank_sel, run_level, gain_now;
  longint unsigned    sq_acc;
  bit                 seeded;
  int unsigned        len_reg, target_reg;

  scaled_out_t        scaled_q[$];
  int unsigned        fail_count = 0;
  bit                 quiet = 1'b0;
  int                 stall_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Frame close: RMS, seed or EMA of the running level, gain and bank swap
  function automatic void close_frame_level();
    longint unsigned n, rms, mix, g, r;
    n = (wr_cnt != 0) ? wr_cnt : 1;
    rms = int_sqrt((sq_acc << 16) / n);
    if (!seeded) begin
      run_level = (rms > 8) ? rms : 8;
      seeded = 1'b1;
    end else if (rms > 8) begin
      mix = 64'd3277 * rms + 64'd62259 * run_level + 64'd32768;
      run_level = (mix >> 16) & 64'hFFFFFF;
    end
    if (run_level > 8) begin
      r = run_level;
      g = ((longint'(target_reg) << 19) + r / 2) / r;
    end else begin
      g = 2048;
    end
    if (g < 205) g = 205;
    if (g > 40960) g = 40960;
    gain_now = g;
    bank_sel ^= 1;
    pend_cnt = wr_cnt;
    rd_cnt = 0;
    wr_cnt = 0;
    sq_acc = 0;
  endfunction

  // Advance the mirror by one transaction; return whether a result is produced
  function automatic bit agc_step(input bit has, input logic signed [15:0] smp,
                                  output scaled_out_t res);
    int unsigned len;
    longint      s, p;
    bit          got;
    len = len_reg;
    if (len == 0) len = 1;
    if (len > MaxFrame) len = MaxFrame;
    got = 1'b0;
    res = '0;
    if (pend_cnt > 0 && rd_cnt < MaxFrame) begin
      s = longint'($signed(store_mem[(bank_sel ^ 1) * MaxFrame + rd_cnt]));
      p = (s * longint'(gain_now) + 1024) >>> 11;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      res.scaled = p[15:0];
      res.gain = gain_now[15:0];
      res.fend = (pend_cnt == 1);
      pend_cnt--;
      rd_cnt++;
      got = 1'b1;
    end
    if (has && wr_cnt < MaxFrame) begin
      s = longint'(smp);
      store_mem[bank_sel * MaxFrame + wr_cnt] = smp;
      sq_acc += longint'(s * s);
      if (sq_acc > 64'hFF_FFFF_FFFF) sq_acc = 64'hFF_FFFF_FFFF;
      wr_cnt++;
      if (wr_cnt >= len) close_frame_level();
    end
    return got;
  endfunction

  // Write one register once every result has arrived and the block has settled
  task automatic write_reg(input cfg_index_e idx, input logic [15:0] data);
    while (scaled_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_FRAME_LENGTH) len_reg = data & 16'h7FF;
    else target_reg = data & 16'h7FFF;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Send one transaction, with an occasional gap before it
  task automatic send_item(input bit has, input logic signed [15:0] smp,
                           input row_check_e chk, input scaled_out_t typed);
    scaled_out_t res;
    bit          got;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.has_sample = has;
    in_if.sample_in  = smp;
    do @(posedge clk_i); while (!in_if.ready);
    got = agc_step(has, smp, res);
    if (chk == CHK_TYPED) begin
      scaled_q.push_back(typed);
    end else if (chk == CHK_NONE) begin
      if (got) report_mismatch("directed row expects no result");
    end else if (got) begin
      scaled_q.push_back(res);
    end
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Drive ready with random stall bursts, or hold it high when quiet
  always @(negedge clk_i) begin
    if (quiet) begin
      out_if.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_if.ready = 1'b0;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    scaled_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (scaled_q.size() == 0) begin
        report_mismatch("result with no expectation waiting");
      end else begin
        want = scaled_q.pop_front();
        if (out_if.scaled_sample !== want.scaled)
          report_mismatch($sformatf("scaled_sample %0d, want %0d",
                                    out_if.scaled_sample, want.scaled));
        if (out_if.frame_gain !== want.gain)
          report_mismatch($sformatf("frame_gain %0d, want %0d", out_if.frame_gain, want.gain));
        if (out_if.frame_end !== want.fend)
          report_mismatch($sformatf("frame_end %0b, want %0b", out_if.frame_end, want.fend));
      end
    end
  end

  function automatic stim_row_t item_row(input bit has, input int smp,
                                         input row_check_e chk = CHK_PREDICT,
                                         input scaled_out_t typed = '0);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.has = has;
    r.sample = smp[15:0];
    r.chk = chk;
    r.typed = typed;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_index_e idx, input int data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample(input int mode);
    case (mode)
      0: return $urandom_range(0, 65535);
      1: return $signed($urandom_range(0, 128)) - 64;
      2: return 16'sd0;
      3: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return $signed($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  initial begin
    stim_row_t   rows[$];
    scaled_out_t typed;
    int          items, phase, n_items, mode, len;

    in_if.valid = 1'b0;
    in_if.has_sample = 1'b0;
    in_if.sample_in = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FRAME_LENGTH;
    cfg_if.data = '0;
    wr_cnt = 0; rd_cnt = 0; pend_cnt = 0; bank_sel = 0;
    sq_acc = 0; run_level = 0; seeded = 1'b0; gain_now = 2048;
    len_reg = FrameLengthReset; target_reg = TargetLevelReset;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: extremes, silent seed, zero length, clamps, length changes
    typed = '{scaled: 16'sd0, gain: 16'd2048, fend: 1'b1};
    rows.push_back(item_row(0, 0, CHK_NONE));
    rows.push_back(cfg_row(CFG_FRAME_LENGTH, 1));
    rows.push_back(item_row(1, 0, CHK_NONE));
    rows.push_back(item_row(0, 0, CHK_TYPED, typed));
    rows.push_back(item_row(1, 32767));
    rows.push_back(item_row(1, -32768));
    rows.push_back(item_row(1, 16'h5555));
    rows.push_back(item_row(1, -21846));
    rows.push_back(item_row(0, 0));
    rows.push_back(cfg_row(CFG_FRAME_LENGTH, 0));
    rows.push_back(item_row(1, 1));
    rows.push_back(item_row(0, 0));
    rows.push_back(cfg_row(CFG_TARGET_LEVEL, 32767));
    rows.push_back(cfg_row(CFG_FRAME_LENGTH, 4));
    rows.push_back(item_row(1, 300));
    rows.push_back(item_row(1, -300));
    rows.push_back(item_row(1, 7));
    rows.push_back(item_row(1, 8));
    rows.push_back(cfg_row(CFG_FRAME_LENGTH, 1));
    rows.push_back(item_row(1, 5));
    rows.push_back(item_row(0, 0));
    rows.push_back(item_row(0, 0));
    rows.push_back(cfg_row(CFG_FRAME_LENGTH, 8));
    rows.push_back(item_row(1, 1000));
    rows.push_back(item_row(1, -1000));
    rows.push_back(item_row(1, 2000));
    rows.push_back(cfg_row(CFG_FRAME_LENGTH, 2));
    rows.push_back(item_row(1, 3));
    rows.push_back(item_row(0, 0));
    rows.push_back(item_row(0, 0));
    rows.push_back(cfg_row(CFG_TARGET_LEVEL, 1));
    rows.push_back(item_row(1, 20000));
    rows.push_back(item_row(1, 20000));
    rows.push_back(item_row(0, 0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        idle_input();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_item(rows[i].has, rows[i].sample, rows[i].chk, rows[i].typed);
      end
    end

    // Random phases, each with its own register setting
    items = 0;
    phase = 0;
    while (items < 1500) begin
      idle_input();
      if (phase == 1) begin
        // oversized length runs full-size frames; all-negative samples saturate the sum
        len = 2047;
        write_reg(CFG_FRAME_LENGTH, len);
        n_items = 1024 + $urandom_range(0, 40);
        mode = 5;
      end else begin
        case ($urandom_range(0, 19))
          0, 1:    len = 0;
          2:       len = $urandom_range(17, 200);
          default: len = $urandom_range(1, 16);
        endcase
        if ($urandom_range(0, 3) != 0) write_reg(CFG_FRAME_LENGTH, len);
        case ($urandom_range(0, 5))
          0: write_reg(CFG_TARGET_LEVEL, 1);
          1: write_reg(CFG_TARGET_LEVEL, 32767);
          2, 3: write_reg(CFG_TARGET_LEVEL, $urandom_range(1, 32767));
          default: ;
        endcase
        n_items = (len == 0 ? 1 : len) * $urandom_range(1, 4) + $urandom_range(0, 3);
        mode = $urandom_range(0, 4);
      end
      for (int k = 0; k < n_items; k++) begin
        if (phase == 0 && k == n_items / 2) begin
          // hold the sender until every pending result has drained out
          idle_input();
          while (scaled_q.size() != 0) @(posedge clk_i);
        end
        if (items > 1350) quiet = 1'b1;
        send_item($urandom_range(0, 9) != 0,
                  (mode == 5) ? 16'sh8000 : pick_sample(mode), CHK_PREDICT, '0);
        items++;
      end
      phase++;
    end
    idle_input();

    while (scaled_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #18_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
